// ===== rtl/ecomp_pkg.sv =====
`timescale 1ns / 1ps
package ecomp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_CALIB    = 3'd0,
    CFG_PRESS_CALIB_A = 3'd1,
    CFG_PRESS_CALIB_B = 3'd2,
    CFG_HUM_CALIB_A   = 3'd3,
    CFG_HUM_CALIB_B   = 3'd4
  } cfg_idx_t;

  // Humidity coefficients as unpacked from the two humidity registers.
  typedef struct packed {
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } hum_coef_t;

  localparam int          HUM_LAT   = 8;
  localparam logic [31:0] HUM_CLAMP = 32'd419430400;

endpackage

// ===== rtl/ecomp_hum.sv =====
`timescale 1ns / 1ps
module ecomp_hum (
  input  logic                  clk,
  input  ecomp_pkg::hum_coef_t  coef,
  input  logic signed [31:0]    x,
  input  logic        [15:0]    raw_h,
  input  logic signed [15:0]    temp_in,
  output logic        [16:0]    hum,
  output logic signed [15:0]    temp_out
);
  import ecomp_pkg::*;

  logic signed [15:0] temp_d [0:HUM_LAT-1];

  logic        [31:0] h1_m5, h1_x6, h1_x3;
  logic        [15:0] h1_rh;
  logic        [16:0] h2_a;
  logic        [21:0] h2_b;
  logic        [31:0] h2_c;
  logic        [16:0] h3_a;
  logic        [31:0] h3_bc;
  logic        [16:0] h4_a;
  logic        [31:0] h4_d2;
  logic        [31:0] h5_x, h6_x, h7_x;
  logic        [31:0] h6_sq;
  logic        [31:0] h7_b2;

  logic signed [43:0] m_h5;
  logic signed [39:0] m_h6;
  logic signed [40:0] m_h3;
  logic        [31:0] aa;
  logic signed [53:0] m_bc;
  logic signed [31:0] hd;
  logic signed [47:0] m_d2;
  logic        [31:0] d8;
  logic signed [34:0] m_x;
  logic signed [16:0] ha6;
  logic signed [33:0] m_sq;
  logic signed [33:0] m_b2;
  logic signed [31:0] res;
  logic        [31:0] res_cl;

  assign m_h5 = $signed(coef.h5) * x;
  assign m_h6 = x * $signed(coef.h6);
  assign m_h3 = x * $signed({1'b0, coef.h3});
  assign aa   = {2'b00, h1_rh, 14'b0} - {coef.h4, 20'b0} - h1_m5 + 32'd16384;
  assign m_bc = $signed(h2_b) * $signed(h2_c);
  assign hd   = $signed({{10{h3_bc[31]}}, h3_bc[31:10]}) + 32'sd2097152;
  assign m_d2 = hd * $signed(coef.h2);
  assign d8   = h4_d2 + 32'd8192;
  assign m_x  = $signed(h4_a) * $signed(d8[31:14]);
  assign ha6  = $signed(h5_x[31:15]);
  assign m_sq = ha6 * ha6;
  assign m_b2 = $signed(h6_sq[31:7]) * $signed({1'b0, coef.h1});
  assign res  = $signed(h7_x - {{4{h7_b2[31]}}, h7_b2[31:4]});

  always_comb begin
    if (res < 0) begin
      res_cl = '0;
    end else if (res > $signed(HUM_CLAMP)) begin
      res_cl = HUM_CLAMP;
    end else begin
      res_cl = res;
    end
  end

  always_ff @(posedge clk) begin
    h1_m5 <= m_h5[31:0];
    h1_x6 <= m_h6[31:0];
    h1_x3 <= m_h3[31:0];
    h1_rh <= raw_h;
    h2_a  <= aa[31:15];
    h2_b  <= h1_x6[31:10];
    h2_c  <= {{11{h1_x3[31]}}, h1_x3[31:11]} + 32'd32768;
    h3_a  <= h2_a;
    h3_bc <= m_bc[31:0];
    h4_a  <= h3_a;
    h4_d2 <= m_d2[31:0];
    h5_x  <= m_x[31:0];
    h6_x  <= h5_x;
    h6_sq <= m_sq[31:0];
    h7_x  <= h6_x;
    h7_b2 <= m_b2[31:0];
    hum   <= res_cl[28:12];
    temp_d[0] <= temp_in;
    for (int k = 1; k < HUM_LAT; k++) begin
      temp_d[k] <= temp_d[k-1];
    end
  end

  assign temp_out = temp_d[HUM_LAT-1];

endmodule

// ===== rtl/ecomp_div.sv =====
`timescale 1ns / 1ps
module ecomp_div #(
  parameter int W      = 64,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_valid,
  output logic signed [W-1:0] quot,
  output logic [SIDE_W-1:0]   side_out
);

  // Stage 0 holds the magnitudes, stages 1 to W each settle one quotient bit.
  logic [W:0]        v_st;
  logic [W:0]        neg_st;
  logic [W-1:0]      rem      [0:W];
  logic [W-1:0]      quo      [0:W];
  logic [W-1:0]      dvs      [0:W];
  logic [SIDE_W-1:0] side_st  [0:W];
  logic [W:0]        sh       [1:W];
  logic [W:0]        diff     [1:W];
  logic [W-1:0]      rem_next [1:W];
  logic [W-1:0]      quo_next [1:W];

  always_comb begin
    for (int k = 1; k <= W; k++) begin
      sh[k]       = {rem[k-1], quo[k-1][W-1]};
      diff[k]     = sh[k] - {1'b0, dvs[k-1]};
      rem_next[k] = diff[k][W] ? sh[k][W-1:0] : diff[k][W-1:0];
      quo_next[k] = {quo[k-1][W-2:0], ~diff[k][W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_st      <= '0;
      out_valid <= 1'b0;
    end else begin
      v_st      <= {v_st[W-1:0], in_valid};
      out_valid <= v_st[W];
    end
  end

  always_ff @(posedge clk) begin
    rem[0]     <= '0;
    quo[0]     <= num[W-1] ? -num : num;
    dvs[0]     <= den[W-1] ? -den : den;
    neg_st[0]  <= num[W-1] ^ den[W-1];
    side_st[0] <= side_in;
    for (int k = 1; k <= W; k++) begin
      rem[k]     <= rem_next[k];
      quo[k]     <= quo_next[k];
      dvs[k]     <= dvs[k-1];
      neg_st[k]  <= neg_st[k-1];
      side_st[k] <= side_st[k-1];
    end
    quot     <= neg_st[W] ? -quo[W] : quo[W];
    side_out <= side_st[W];
  end

endmodule

// ===== rtl/env_sensor_compensation_top.sv =====
`timescale 1ns / 1ps
// Environmental sensor compensation pipeline.
// A raw sample (temperature, pressure, humidity) is transferred in at a clock
// edge where start is high and busy is low. Busy is only high during reset,
// so a new sample may be transferred on every clock: one sample per cycle.
// Each result appears on the result ports for exactly one cycle with done
// high. A sample passes the temperature and pressure stages, then the
// 64-stage signed divider of the pressure path, which settles one quotient
// bit per stage, then the correction stages and the output registers. The
// temperature and humidity results ride a delay line so that all fields of
// one sample leave together. Results come out in the order the samples
// went in.
// The calibration registers are written over the cfg channel, which is
// always ready; a write to an index past the last register is dropped.
// Calibration should only be written while no sample is in flight.
// Reset clears the calibration registers to zero and discards every sample
// in flight; no done strobe follows a reset until new samples arrive.
// The receiver cannot stall the block, so it must take each result on the
// cycle that done is high.
module env_sensor_compensation_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [19:0]                        raw_temperature,
  input  logic [19:0]                        raw_pressure,
  input  logic [15:0]                        raw_humidity,
  output logic                               done,
  output logic signed [15:0]                 temperature_centi,
  output logic [31:0]                        pressure_q24_8,
  output logic                               pressure_invalid,
  output logic [16:0]                        humidity_q22_10,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ecomp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ecomp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ecomp_pkg::*;

  localparam int DIV_W    = 64;
  localparam int PRE_LAT  = 5;
  localparam int POST_LAT = 4;
  localparam int SIDE_DLY = PRE_LAT + DIV_W + 2 + POST_LAT - HUM_LAT;

  // Low 64 bits of a 64-bit word times a signed 17-bit coefficient, built
  // from two narrow products on the halves of the word.
  function automatic logic [63:0] mul_lo(input logic [63:0] a,
                                         input logic signed [16:0] b);
    logic signed [49:0] lo;
    logic        [31:0] hi;
    lo = $signed({1'b0, a[31:0]}) * b;
    hi = a[63:32] * {{15{b[16]}}, b};
    return {{14{lo[49]}}, lo} + {hi, 32'b0};
  endfunction

  // Calibration registers and the coefficients packed inside them.
  logic [47:0] temp_calib;
  logic [63:0] press_calib_a;
  logic [63:0] press_calib_b;
  logic [47:0] hum_calib_a;
  logic [31:0] hum_calib_b;

  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  hum_coef_t          hcoef;

  assign t1 = temp_calib[15:0];
  assign t2 = temp_calib[31:16];
  assign t3 = temp_calib[47:32];
  assign p1 = press_calib_a[15:0];
  assign p2 = press_calib_a[31:16];
  assign p3 = press_calib_a[47:32];
  assign p4 = press_calib_a[63:48];
  assign p5 = press_calib_b[15:0];
  assign p6 = press_calib_b[31:16];
  assign p7 = press_calib_b[47:32];
  assign p8 = press_calib_b[63:48];
  assign p9 = hum_calib_a[15:0];
  assign hcoef.h1 = hum_calib_a[23:16];
  assign hcoef.h2 = hum_calib_a[39:24];
  assign hcoef.h3 = hum_calib_a[47:40];
  assign hcoef.h4 = hum_calib_b[11:0];
  assign hcoef.h5 = hum_calib_b[23:12];
  assign hcoef.h6 = hum_calib_b[31:24];

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      hum_calib_a   <= '0;
      hum_calib_b   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEMP_CALIB:    temp_calib    <= cfg_data[47:0];
        CFG_PRESS_CALIB_A: press_calib_a <= cfg_data;
        CFG_PRESS_CALIB_B: press_calib_b <= cfg_data;
        CFG_HUM_CALIB_A:   hum_calib_a   <= cfg_data[47:0];
        CFG_HUM_CALIB_B:   hum_calib_b   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Valid bits of the four temperature stages and the five pressure stages
  // ahead of the divider, then of the four stages behind it.
  logic [PRE_LAT+3:0]  pre_v;
  logic [POST_LAT-1:0] post_v;
  logic                div_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_v  <= '0;
      post_v <= '0;
      done   <= 1'b0;
    end else begin
      pre_v  <= {pre_v[PRE_LAT+2:0], start && !busy};
      post_v <= {post_v[POST_LAT-2:0], div_v};
      done   <= post_v[POST_LAT-1];
    end
  end

  // Fine temperature over four stages.
  logic signed [17:0] s1_dt;
  logic signed [33:0] s1_ma;
  logic signed [16:0] s1_d;
  logic signed [33:0] s1_mdd;
  logic signed [35:0] s2_mb;
  logic        [31:0] s4_t8;
  logic signed [23:0] s4_t24;
  logic        [15:0] s4_sat;

  logic [31:0] s1_a, s1_dd;
  logic [20:0] s2_a;
  logic [31:0] s2_b, s3_tf;
  logic [19:0] s1_rp, s2_rp, s3_rp, s4_rp, p1_rp, p2_rp, p3_rp;
  logic [15:0] s1_rh, s2_rh, s3_rh, s4_rh;
  logic [15:0] s4_temp;
  logic [31:0] s4_x;
  logic signed [32:0] s4_u1;

  assign s1_dt  = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign s1_ma  = s1_dt * t2;
  assign s1_d   = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
  assign s1_mdd = s1_d * s1_d;
  assign s2_mb  = $signed(s1_dd[31:12]) * t3;
  assign s4_t8  = {s3_tf[29:0], 2'b00} + s3_tf + 32'd128;
  assign s4_t24 = s4_t8[31:8];

  always_comb begin
    if (s4_t24 > 24'sd32767) begin
      s4_sat = 16'h7FFF;
    end else if (s4_t24 < -24'sd32768) begin
      s4_sat = 16'h8000;
    end else begin
      s4_sat = s4_t24[15:0];
    end
  end

  always_ff @(posedge clk) begin
    s1_a    <= s1_ma[31:0];
    s1_dd   <= s1_mdd[31:0];
    s1_rp   <= raw_pressure;
    s1_rh   <= raw_humidity;
    s2_a    <= s1_a[31:11];
    s2_b    <= s2_mb[31:0];
    s2_rp   <= s1_rp;
    s2_rh   <= s1_rh;
    s3_tf   <= {{11{s2_a[20]}}, s2_a} + {{14{s2_b[31]}}, s2_b[31:14]};
    s3_rp   <= s2_rp;
    s3_rh   <= s2_rh;
    s4_temp <= s4_sat;
    s4_x    <= s3_tf - 32'd76800;
    s4_u1   <= $signed({s3_tf[31], s3_tf}) - 33'sd128000;
    s4_rp   <= s3_rp;
    s4_rh   <= s3_rh;
  end

  // Pressure: divisor and dividend over five stages, all modulo 2^64.
  logic signed [65:0] p1_muu;
  logic signed [48:0] p1_m5, p1_m2;
  logic        [20:0] p4_pu;

  logic [63:0] p1_uu, p2_v6, p2_v3, p3_uv1, p3_uv2, p4_pm, p4_nm, p5_num, p5_den;
  logic [48:0] p1_u5, p1_u2, p2_u5, p2_u2;
  logic        p5_inv;

  assign p1_muu = s4_u1 * s4_u1;
  assign p1_m5  = s4_u1 * p5;
  assign p1_m2  = s4_u1 * p2;
  assign p4_pu  = 21'd1048576 - {1'b0, p3_rp};

  always_ff @(posedge clk) begin
    p1_uu  <= p1_muu[63:0];
    p1_u5  <= p1_m5;
    p1_u2  <= p1_m2;
    p1_rp  <= s4_rp;
    p2_v6  <= mul_lo(p1_uu, {p6[15], p6});
    p2_v3  <= mul_lo(p1_uu, {p3[15], p3});
    p2_u5  <= p1_u5;
    p2_u2  <= p1_u2;
    p2_rp  <= p1_rp;
    p3_uv2 <= p2_v6 + {{15{p2_u5[48]}}, p2_u5[48:0]} * 64'd131072
              + {{13{p4[15]}}, p4, 35'b0};
    p3_uv1 <= {{8{p2_v3[63]}}, p2_v3[63:8]} + {{15{p2_u2[48]}}, p2_u2[48:0]} * 64'd4096;
    p3_rp  <= p2_rp;
    p4_pm  <= mul_lo(64'h0000_8000_0000_0000 + p3_uv1, {1'b0, p1});
    p4_nm  <= {12'b0, p4_pu, 31'b0} - p3_uv2;
    p5_num <= p4_nm * 64'd3125;
    p5_den <= {{33{p4_pm[63]}}, p4_pm[63:33]};
    p5_inv <= (p4_pm[63:33] == 31'd0);
  end

  logic [63:0] div_q;
  logic        div_inv;

  ecomp_div #(
    .W      (DIV_W),
    .SIDE_W (1)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pre_v[PRE_LAT+3]),
    .num       (p5_num),
    .den       (p5_den),
    .side_in   (p5_inv),
    .out_valid (div_v),
    .quot      (div_q),
    .side_out  (div_inv)
  );

  // Second-order correction after the division.
  logic [63:0] q1_q13;
  logic [63:0] q1_q, q1_ll, q1_e2p, q2_q, q2_sq, q2_e2, q3_q, q3_e1p, q3_e2, q4_r;
  logic [31:0] q1_hl;
  logic        q1_inv, q2_inv, q3_inv, q4_inv;
  logic [63:0] q4_sum, q5_r;

  assign q1_q13 = {{13{div_q[63]}}, div_q[63:13]};
  assign q4_sum = q3_q + {{25{q3_e1p[63]}}, q3_e1p[63:25]} + q3_e2;
  assign q5_r   = q4_r + {{44{p7[15]}}, p7, 4'b0};

  always_ff @(posedge clk) begin
    q1_q   <= div_q;
    q1_ll  <= {32'b0, q1_q13[31:0]} * {32'b0, q1_q13[31:0]};
    q1_hl  <= q1_q13[63:32] * q1_q13[31:0];
    q1_e2p <= mul_lo(div_q, {p8[15], p8});
    q1_inv <= div_inv;
    q2_q   <= q1_q;
    q2_sq  <= q1_ll + {q1_hl[30:0], 33'b0};
    q2_e2  <= {{19{q1_e2p[63]}}, q1_e2p[63:19]};
    q2_inv <= q1_inv;
    q3_q   <= q2_q;
    q3_e1p <= mul_lo(q2_sq, {p9[15], p9});
    q3_e2  <= q2_e2;
    q3_inv <= q2_inv;
    q4_r   <= {{8{q4_sum[63]}}, q4_sum[63:8]};
    q4_inv <= q3_inv;
  end

  // Humidity runs beside the pressure path and waits on a delay line.
  logic [16:0]        hum_val;
  logic signed [15:0] hum_temp;
  logic [32:0]        side_d [0:SIDE_DLY-1];

  ecomp_hum u_hum (
    .clk      (clk),
    .coef     (hcoef),
    .x        (s4_x),
    .raw_h    (s4_rh),
    .temp_in  (s4_temp),
    .hum      (hum_val),
    .temp_out (hum_temp)
  );

  always_ff @(posedge clk) begin
    side_d[0] <= {hum_temp, hum_val};
    for (int k = 1; k < SIDE_DLY; k++) begin
      side_d[k] <= side_d[k-1];
    end
    temperature_centi <= side_d[SIDE_DLY-1][32:17];
    humidity_q22_10   <= side_d[SIDE_DLY-1][16:0];
    pressure_invalid  <= q4_inv;
    if (q4_inv || q5_r[63]) begin
      pressure_q24_8 <= '0;
    end else if (q5_r[63:32] != 32'd0) begin
      pressure_q24_8 <= '1;
    end else begin
      pressure_q24_8 <= q5_r[31:0];
    end
  end

endmodule

// ===== rtl/ecomp_chk.sv =====
`timescale 1ns / 1ps
module ecomp_chk (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] pressure_q24_8,
  input logic        pressure_invalid,
  input logic [16:0] humidity_q22_10
);

  localparam int LAT = 80;

  // Every accepted sample leaves with its own done strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("result missing after a sample transfer");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && pressure_invalid |-> pressure_q24_8 == 32'd0)
    else $error("pressure not zero with invalid divisor");

  a_hum_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> humidity_q22_10 <= 17'd102400)
    else $error("humidity above full scale");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe straight after reset");

endmodule

bind env_sensor_compensation_top ecomp_chk u_ecomp_chk (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ecomp_pkg::*;

  // The result of one sample, as it leaves the block.
  typedef struct {
    logic signed [15:0] temp;
    logic [31:0]        press;
    logic               invalid;
    logic [16:0]        hum;
  } reading_t;

  // One row of the directed stimulus. Rows marked typed carry their result
  // written out by hand; the rest go through the predictor.
  typedef struct {
    logic [19:0] rt;
    logic [19:0] rp;
    logic [15:0] rh;
    bit          typed;
    reading_t    res;
  } sample_row_t;

  localparam int          LATENCY      = 80;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          N_TYPED      = 6;
  localparam int          N_DIRECTED   = 20;
  localparam int          N_PHASES     = 8;
  localparam logic [2:0]  CFG_IDX_NONE = 3'd7;
  localparam longint      INT64_MIN_V  = 64'sh8000_0000_0000_0000;

  // Calibration words typical of a production part, packed as the registers
  // expect them.
  localparam logic [47:0] TYP_TEMP    = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PRESS_A = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_PRESS_B = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [47:0] TYP_HUM_A   = {8'd0, 16'd362, 8'd75, 16'd6000};
  localparam logic [31:0] TYP_HUM_B   = {8'd30, 12'd50, 12'd313};

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;
  logic        done;
  logic signed [15:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic        pressure_invalid;
  logic [16:0] humidity_q22_10;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  env_sensor_compensation_top u_dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .raw_temperature   (raw_temperature),
    .raw_pressure      (raw_pressure),
    .raw_humidity      (raw_humidity),
    .done              (done),
    .temperature_centi (temperature_centi),
    .pressure_q24_8    (pressure_q24_8),
    .pressure_invalid  (pressure_invalid),
    .humidity_q22_10   (humidity_q22_10),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // The testbench's own copy of the calibration registers.
  logic [47:0] temp_cal;
  logic [63:0] press_cal_a;
  logic [63:0] press_cal_b;
  logic [47:0] hum_cal_a;
  logic [31:0] hum_cal_b;

  // Results that have been predicted but not yet seen, oldest first.
  reading_t pending_results[$];
  int       errors;
  int       cycles;
  int       idle_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Wrap to the signed 32-bit range, as a 32-bit datapath stage would.
  function automatic longint w32(input longint v);
    return longint'(int'(v));
  endfunction

  // Compensate one raw sample against the current calibration. All arithmetic
  // is on 64-bit signed values; the 32-bit stages are folded back with w32 and
  // the right shifts are arithmetic, so they floor as the datapath does.
  function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp,
                                          input logic [15:0] rh);
    reading_t res;
    longint adc_t, adc_p, adc_h;
    longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint h1, h2, h3, h4, h5, h6;
    longint a, b, c, d, x, t_fine, temp;
    longint u1, uv1, uv2, den, num, q, q13, e1, e2, r;
    adc_t = longint'(rt);
    adc_p = longint'(rp);
    adc_h = longint'(rh);
    t1 = longint'(temp_cal[15:0]);
    t2 = longint'($signed(temp_cal[31:16]));
    t3 = longint'($signed(temp_cal[47:32]));
    p1 = longint'(press_cal_a[15:0]);
    p2 = longint'($signed(press_cal_a[31:16]));
    p3 = longint'($signed(press_cal_a[47:32]));
    p4 = longint'($signed(press_cal_a[63:48]));
    p5 = longint'($signed(press_cal_b[15:0]));
    p6 = longint'($signed(press_cal_b[31:16]));
    p7 = longint'($signed(press_cal_b[47:32]));
    p8 = longint'($signed(press_cal_b[63:48]));
    p9 = longint'($signed(hum_cal_a[15:0]));
    h1 = longint'(hum_cal_a[23:16]);
    h2 = longint'($signed(hum_cal_a[39:24]));
    h3 = longint'(hum_cal_a[47:40]);
    h4 = longint'($signed(hum_cal_b[11:0]));
    h5 = longint'($signed(hum_cal_b[23:12]));
    h6 = longint'($signed(hum_cal_b[31:24]));

    // Fine temperature, then hundredths of a degree.
    a = w32(((adc_t >>> 3) - 2 * t1) * t2) >>> 11;
    d = (adc_t >>> 4) - t1;
    b = w32((w32(d * d) >>> 12) * t3) >>> 14;
    t_fine = w32(a + b);
    temp = w32(w32(t_fine * 5) + 128) >>> 8;
    if (temp > 32767) temp = 32767;
    if (temp < -32768) temp = -32768;
    res.temp = temp[15:0];

    // Pressure on the 64-bit path; a zero divisor flags the result invalid.
    u1  = t_fine - 128000;
    uv2 = u1 * u1 * p6 + ((u1 * p5) << 17) + (p4 << 35);
    uv1 = ((u1 * u1 * p3) >>> 8) + ((u1 * p2) << 12);
    den = (((64'sd1 <<< 47) + uv1) * p1) >>> 33;
    res.invalid = (den == 0);
    res.press   = '0;
    if (den != 0) begin
      num = (((64'sd1048576 - adc_p) << 31) - uv2) * 3125;
      if (num == INT64_MIN_V && den == -1) begin
        q = INT64_MIN_V;
      end else begin
        q = num / den;
      end
      q13 = q >>> 13;
      e1  = (p9 * q13 * q13) >>> 25;
      e2  = (p8 * q) >>> 19;
      r   = ((q + e1 + e2) >>> 8) + (p7 << 4);
      if (r < 0) r = 0;
      if (r > 64'sd4294967295) r = 64'sd4294967295;
      res.press = r[31:0];
    end

    // Relative humidity on the 32-bit path, clamped to 0..100 %.
    x = w32(t_fine - 76800);
    a = w32(w32(w32(adc_h * 16384) - w32(h4 * 1048576)) - w32(h5 * x));
    a = w32(a + 16384) >>> 15;
    b = w32(x * h6) >>> 10;
    c = w32((w32(x * h3) >>> 11) + 32768);
    d = w32((w32(b * c) >>> 10) + 2097152);
    d = w32(w32(d * h2) + 8192) >>> 14;
    x = w32(a * d);
    a = x >>> 15;
    b = w32((w32(a * a) >>> 7) * h1) >>> 4;
    x = w32(x - b);
    if (x < 0) x = 0;
    if (x > longint'(HUM_CLAMP)) x = longint'(HUM_CLAMP);
    res.hum = x[28:12];
    return res;
  endfunction

  // Write one calibration register over the configuration channel and keep
  // the local copy in step. An index past the last register changes nothing.
  task automatic write_calib(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TEMP_CALIB:    temp_cal    = data[47:0];
      CFG_PRESS_CALIB_A: press_cal_a = data;
      CFG_PRESS_CALIB_B: press_cal_b = data;
      CFG_HUM_CALIB_A:   hum_cal_a   = data[47:0];
      CFG_HUM_CALIB_B:   hum_cal_b   = data[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all_calib(input logic [47:0] tc, input logic [63:0] pa,
                                 input logic [63:0] pb, input logic [47:0] ha,
                                 input logic [31:0] hb);
    write_calib(CFG_TEMP_CALIB, {16'($urandom), tc});
    write_calib(CFG_PRESS_CALIB_A, pa);
    write_calib(CFG_PRESS_CALIB_B, pb);
    write_calib(CFG_HUM_CALIB_A, {16'($urandom), ha});
    write_calib(CFG_HUM_CALIB_B, {$urandom, hb});
  endtask

  // Offer one sample. The sender may sit idle first; the transfer happens at
  // the first rising edge with start high and busy low. Called at a falling
  // edge and returns at one, without touching start on the way out, so a
  // back-to-back stream keeps start high throughout.
  task automatic send_sample(input logic [19:0] rt, input logic [19:0] rp,
                             input logic [15:0] rh, input bit typed, input reading_t res);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    raw_temperature <= rt;
    raw_pressure    <= rp;
    raw_humidity    <= rh;
    do @(posedge clk); while (busy);
    pending_results.push_back(typed ? res : compensate(rt, rp, rh));
    @(negedge clk);
  endtask

  // Stop offering samples and wait until every predicted result has come,
  // then give the pipeline its full latency once more before going on.
  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Results are taken on the edge that ends their done cycle.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no sample outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("temperature_centi", longint'(want.temp), longint'(temperature_centi));
        check_field("pressure_q24_8", longint'(want.press), longint'(pressure_q24_8));
        check_field("pressure_invalid", longint'(want.invalid), longint'(pressure_invalid));
        check_field("humidity_q22_10", longint'(want.hum), longint'(humidity_q22_10));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL env_sensor_compensation_top");
      $finish;
    end
  end

  // Stimulus. The run starts with a directed table: the first rows run on the
  // reset calibration, where every coefficient is zero. There the fine
  // temperature is zero, the pressure divisor is zero so pressure comes back
  // invalid and zero, and the humidity gain is zero, whatever the raw values
  // are; those rows carry their results typed in. The rest of the table runs
  // on typical calibration and is checked through the predictor. After that
  // come random phases, each with its own calibration and idling pattern.
  initial begin
    sample_row_t rows[N_DIRECTED];
    reading_t    zero_cal;
    reading_t    unused;
    logic [19:0] rt, rp;
    logic [15:0] rh;
    logic [63:0] w0, w1, w2, w3, w4;
    int          n_items;
    int          sel;
    int          pct[N_PHASES];

    zero_cal = '{temp: 16'sd0, press: 32'd0, invalid: 1'b1, hum: 17'd0};
    unused   = zero_cal;
    rows = '{
      '{20'd0,       20'd0,       16'd0,      1'b1, zero_cal},
      '{20'hFFFFF,   20'hFFFFF,   16'hFFFF,   1'b1, zero_cal},
      '{20'd0,       20'hFFFFF,   16'd0,      1'b1, zero_cal},
      '{20'hFFFFF,   20'd0,       16'hFFFF,   1'b1, zero_cal},
      '{20'h80000,   20'h80000,   16'h8000,   1'b1, zero_cal},
      '{20'h7FFFF,   20'h7FFFF,   16'h7FFF,   1'b1, zero_cal},
      '{20'd519888,  20'd415148,  16'd30000,  1'b0, unused},
      '{20'd519888,  20'd0,       16'd30000,  1'b0, unused},
      '{20'd519888,  20'hFFFFF,   16'd30000,  1'b0, unused},
      '{20'd519888,  20'd415148,  16'd0,      1'b0, unused},
      '{20'd519888,  20'd415148,  16'hFFFF,   1'b0, unused},
      '{20'd0,       20'd415148,  16'd30000,  1'b0, unused},
      '{20'hFFFFF,   20'd415148,  16'd30000,  1'b0, unused},
      '{20'd440000,  20'd350000,  16'd20000,  1'b0, unused},
      '{20'd600000,  20'd300000,  16'd45000,  1'b0, unused},
      '{20'd0,       20'd0,       16'd0,      1'b0, unused},
      '{20'hFFFFF,   20'hFFFFF,   16'hFFFF,   1'b0, unused},
      '{20'h55555,   20'hAAAAA,   16'h5555,   1'b0, unused},
      '{20'hAAAAA,   20'h55555,   16'hAAAA,   1'b0, unused},
      '{20'd530000,  20'd400000,  16'd38000,  1'b0, unused}
    };
    // Sender idle share per random phase: none, heavy, moderate.
    pct = '{0, 68, 38, 0, 68, 38, 0, 68};

    rst             = 1'b1;
    start           = 1'b0;
    raw_temperature = '0;
    raw_pressure    = '0;
    raw_humidity    = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    temp_cal        = '0;
    press_cal_a     = '0;
    press_cal_b     = '0;
    hum_cal_a       = '0;
    hum_cal_b       = '0;
    idle_pct        = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (i == N_TYPED) begin
        drain();
        write_all_calib(TYP_TEMP, TYP_PRESS_A, TYP_PRESS_B, TYP_HUM_A, TYP_HUM_B);
      end
      send_sample(rows[i].rt, rows[i].rp, rows[i].rh, rows[i].typed, rows[i].res);
    end
    // Pause the sender until the block has gone quiet.
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // Calibration for this phase: typical, typical with noise, fully random,
      // all ones, and the most negative signed words with unsigned fields full.
      case (ph % 5)
        0: begin
          w0 = TYP_TEMP; w1 = TYP_PRESS_A; w2 = TYP_PRESS_B;
          w3 = TYP_HUM_A; w4 = TYP_HUM_B;
        end
        1: begin
          w0 = TYP_TEMP ^ {16'($urandom_range(0, 255)), 16'($urandom_range(0, 1023)),
                           16'($urandom_range(0, 255))};
          w1 = TYP_PRESS_A ^ {16'($urandom_range(0, 63)), 16'($urandom_range(0, 255)),
                              16'($urandom_range(0, 255)), 16'($urandom_range(0, 1023))};
          w2 = TYP_PRESS_B ^ {16'($urandom_range(0, 255)), 16'($urandom_range(0, 1023)),
                              16'($urandom_range(0, 15)), 16'($urandom_range(0, 63))};
          w3 = TYP_HUM_A ^ {8'($urandom_range(0, 15)), 16'($urandom_range(0, 63)),
                            8'($urandom_range(0, 31)), 16'($urandom_range(0, 1023))};
          w4 = TYP_HUM_B ^ {8'($urandom_range(0, 15)), 12'($urandom_range(0, 31)),
                            12'($urandom_range(0, 63))};
        end
        2: begin
          w0 = {$urandom, $urandom}; w1 = {$urandom, $urandom};
          w2 = {$urandom, $urandom}; w3 = {$urandom, $urandom};
          w4 = {$urandom, $urandom};
        end
        3: begin
          w0 = '1; w1 = '1; w2 = '1; w3 = '1; w4 = '1;
        end
        default: begin
          w0 = 48'h8000_8000_FFFF;
          w1 = 64'h8000_8000_8000_FFFF;
          w2 = 64'h8000_8000_8000_8000;
          w3 = 48'hFF_8000_FF_8000;
          w4 = 32'h80_800_800;
        end
      endcase
      write_all_calib(w0[47:0], w1, w2, w3[47:0], w4[31:0]);
      // A write to an index with no register behind it must change nothing.
      if ($urandom_range(0, 1)) write_calib(CFG_IDX_NONE, {$urandom, $urandom});

      idle_pct = pct[ph];
      n_items  = 190;
      for (int k = 0; k < n_items; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
          // Readings a working sensor would give.
          rt = 20'($urandom_range(400000, 640000));
          rp = 20'($urandom_range(250000, 480000));
          rh = 16'($urandom_range(15000, 50000));
        end else begin
          rt = 20'($urandom);
          rp = 20'($urandom);
          rh = 16'($urandom);
        end
        send_sample(rt, rp, rh, 1'b0, unused);
      end
      drain();
    end

    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
    end
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS env_sensor_compensation_top");
    end else begin
      $display("FAIL env_sensor_compensation_top");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ecomp_pkg.sv
rtl/ecomp_hum.sv
rtl/ecomp_div.sv
rtl/env_sensor_compensation_top.sv
rtl/ecomp_chk.sv
test/tb.sv
